@@ src/nrt_pkg.sv @@
package nrt_pkg;

    // Default sizing of the tracker
    localparam int MAX_CHUNKS_DEF = 4096;
    localparam int MAX_RANGES_DEF = 32;

    // Field widths of the stream words
    localparam int SEQ_W   = 32;
    localparam int TOTAL_W = 32;
    localparam int RANGE_W = 12;
    localparam int COUNT_W = 13;

    // Input action codes
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_SCAN   = 1'b1;

    // Result kind codes
    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_FIN   = 1'b1;

    // Control from the sequencer to the bitmap store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } t_bm_ctrl;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_PKT     = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_EMIT_RD = 7'b0010000,
        ST_EMIT_WR = 7'b0100000,
        ST_FIN     = 7'b1000000
    } t_state;

endpackage

@@ src/nrt_if.sv @@
interface nrt_in_if;
    import nrt_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [SEQ_W-1:0]   seq_num;
    logic [TOTAL_W-1:0] announced_total;

    modport source (output valid, action, seq_num, announced_total, input ready);
    modport sink (input valid, action, seq_num, announced_total, output ready);
endinterface

interface nrt_out_if;
    import nrt_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [RANGE_W-1:0] range_first;
    logic [RANGE_W-1:0] range_final;
    logic               truncated;
    logic               last;
    logic [COUNT_W-1:0] count_received;
    logic [RANGE_W-1:0] highest_seen;

    modport source (
        output valid, kind, range_first, range_final, truncated, last,
               count_received, highest_seen,
        input  ready
    );
    modport sink (
        input  valid, kind, range_first, range_final, truncated, last,
               count_received, highest_seen,
        output ready
    );
endinterface

@@ src/nrt_bitmap.sv @@
module nrt_bitmap #(
    parameter int MAX_CHUNKS = nrt_pkg::MAX_CHUNKS_DEF,
    parameter int CW         = $clog2(MAX_CHUNKS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nrt_pkg::t_bm_ctrl i_ctrl,
    input  logic [CW-1:0]     i_rd_addr,
    input  logic [CW-1:0]     i_wr_addr,
    output logic              o_rd_bit,
    output logic              o_busy
);
    import nrt_pkg::*;

    logic          r_mem [MAX_CHUNKS];
    logic          r_rd_bit;
    logic          r_busy;
    logic [CW-1:0] r_clr_addr;
    logic [CW-1:0] n_clr_addr;
    logic          n_busy;

    // Advance the clearing pass, one entry a cycle
    always_comb begin
        n_busy     = r_busy;
        n_clr_addr = r_clr_addr;
        if (r_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == CW'(MAX_CHUNKS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Write port: clearing pass first, then sequencer writes
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctrl.wr_bit;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_bit <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;
    assign o_busy   = r_busy;

endmodule

@@ src/nack_range_tracker_top.sv @@
// Receiver-side chunk tracker for a selective-repeat transfer. Each input word
// is either a packet arrival (action 0), which marks its chunk in an on-chip
// bitmap and gives no result, or a scan (action 1), which walks the bitmap
// below the highest chunk seen and returns one word per run of missing chunks
// (up to MAX_RANGES, with truncated set on all of them if more runs exist), or
// a single FIN word once every chunk has arrived; after FIN all input words are
// dropped. After reset the bitmap is cleared one entry per cycle, so no input
// word is taken until the clearing pass is done. A packet is a read and a
// write back through the bitmap. A scan walks the bitmap one entry per cycle
// through its registered read port, and then gives each missing-range word by
// a run table read, then an output load, waiting while the output is stalled.
// One word is in work at a time; the input is ready whenever the sequencer is
// idle, even while the last result still waits in the output register.
module nack_range_tracker_top #(
    parameter int MAX_CHUNKS = nrt_pkg::MAX_CHUNKS_DEF,
    parameter int MAX_RANGES = nrt_pkg::MAX_RANGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nrt_in_if.sink    i_in,
    nrt_out_if.source o_out
);
    import nrt_pkg::*;

    localparam int CW = $clog2(MAX_CHUNKS);
    localparam int EW = $clog2(MAX_CHUNKS + 1);
    localparam int RW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int NW = $clog2(MAX_RANGES + 2);

    // Sequencer and tracker state
    t_state        r_state, n_state;
    logic [EW-1:0] r_expected, n_expected;
    logic [CW-1:0] r_highest, n_highest;
    logic [EW-1:0] r_count, n_count;
    logic          r_finished, n_finished;

    // Scan walk
    logic          r_issuing, n_issuing;
    logic          r_pv, n_pv;
    logic          r_in_run, n_in_run;
    logic [NW-1:0] r_runs, n_runs;
    logic [NW-1:0] r_k, n_k;
    logic [CW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_start, n_start;
    logic [CW-1:0] r_seq, n_seq;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [RANGE_W-1:0] r_first, n_first;
    logic [RANGE_W-1:0] r_final, n_final;
    logic               r_trunc, n_trunc;
    logic               r_last, n_last;
    logic [COUNT_W-1:0] r_cnt_out, n_cnt_out;
    logic [RANGE_W-1:0] r_high_out, n_high_out;

    // Run table
    logic [2*CW-1:0] r_res_mem [MAX_RANGES];
    logic [2*CW-1:0] r_res_rd;
    logic            res_we;
    logic [RW-1:0]   res_waddr;
    logic [2*CW-1:0] res_wdata;

    // Bitmap port
    t_bm_ctrl      bm_ctrl;
    logic [CW-1:0] bm_rd_addr;
    logic          bm_rd_bit;
    logic          bm_busy;

    logic               in_fire;
    logic               out_free;
    logic [TOTAL_W-1:0] lim_total;
    logic               missing;
    logic [NW-1:0]      n_res;
    logic               trunc;
    logic               res_last;

    nrt_bitmap #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .CW         (CW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (bm_ctrl),
        .i_rd_addr (bm_rd_addr),
        .i_wr_addr (r_seq),
        .o_rd_bit  (bm_rd_bit),
        .o_busy    (bm_busy)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    // Bound for an arriving chunk: the latched total, or the one being latched
    assign lim_total = (r_expected == '0) ? i_in.announced_total : TOTAL_W'(r_expected);

    assign missing  = (r_pidx != r_highest) && !bm_rd_bit;
    assign trunc    = (r_runs > NW'(MAX_RANGES));
    assign n_res    = trunc ? NW'(MAX_RANGES) : r_runs;
    assign res_last = ((r_k + 1'b1) == n_res);

    // Next state of sequencer, tracker and output word
    always_comb begin
        n_state     = r_state;
        n_expected  = r_expected;
        n_highest   = r_highest;
        n_count     = r_count;
        n_finished  = r_finished;
        n_issuing   = r_issuing;
        n_pv        = 1'b0;
        n_in_run    = r_in_run;
        n_runs      = r_runs;
        n_k         = r_k;
        n_addr      = r_addr;
        n_pidx      = r_pidx;
        n_start     = r_start;
        n_seq       = r_seq;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_first     = r_first;
        n_final     = r_final;
        n_trunc     = r_trunc;
        n_last      = r_last;
        n_cnt_out   = r_cnt_out;
        n_high_out  = r_high_out;
        bm_ctrl     = '0;
        bm_rd_addr  = r_addr;
        res_we      = 1'b0;
        res_waddr   = r_runs[RW-1:0];
        res_wdata   = {r_start, r_pidx - 1'b1};

        unique case (r_state)
            ST_CLEAR: begin
                if (!bm_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire && !r_finished) begin
                    if (i_in.action == ACT_PACKET) begin
                        // Drop an oversized announcement while the total is unknown
                        if (!((r_expected == '0) &&
                              (i_in.announced_total > TOTAL_W'(MAX_CHUNKS)))) begin
                            if (r_expected == '0) begin
                                n_expected = EW'(i_in.announced_total);
                            end
                            if (i_in.seq_num < lim_total) begin
                                bm_ctrl.rd_en = 1'b1;
                                bm_rd_addr    = CW'(i_in.seq_num);
                                n_seq         = CW'(i_in.seq_num);
                                n_state       = ST_PKT;
                            end
                        end
                    end else if (r_expected != '0) begin
                        n_addr    = '0;
                        n_issuing = 1'b1;
                        n_in_run  = 1'b0;
                        n_runs    = '0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_PKT: begin
                // Write back a newly received chunk
                if (!bm_rd_bit) begin
                    bm_ctrl.wr_en  = 1'b1;
                    bm_ctrl.wr_bit = 1'b1;
                    n_count        = r_count + 1'b1;
                    if (r_seq > r_highest) begin
                        n_highest = r_seq;
                    end
                end
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                // Issue the next bitmap read up to the highest chunk
                if (r_issuing) begin
                    bm_ctrl.rd_en = 1'b1;
                    n_pv          = 1'b1;
                    n_pidx        = r_addr;
                    n_addr        = r_addr + 1'b1;
                    if (r_addr == r_highest) begin
                        n_issuing = 1'b0;
                    end
                end
                // Track runs of missing chunks on the returned bit
                if (r_pv) begin
                    if (missing && !r_in_run) begin
                        n_in_run = 1'b1;
                        n_start  = r_pidx;
                    end else if (!missing && r_in_run) begin
                        n_in_run = 1'b0;
                        if (r_runs < NW'(MAX_RANGES)) begin
                            res_we = 1'b1;
                        end
                        if (r_runs != NW'(MAX_RANGES + 1)) begin
                            n_runs = r_runs + 1'b1;
                        end
                    end
                    if (r_pidx == r_highest) begin
                        n_k = '0;
                        if (n_runs != '0) begin
                            n_state = ST_EMIT_RD;
                        end else if (r_count >= r_expected) begin
                            n_state = ST_FIN;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_RANGE;
                    n_first     = RANGE_W'(r_res_rd[2*CW-1:CW]);
                    n_final     = RANGE_W'(r_res_rd[CW-1:0]);
                    n_trunc     = trunc;
                    n_last      = res_last;
                    n_cnt_out   = COUNT_W'(r_count);
                    n_high_out  = RANGE_W'(r_highest);
                    n_k         = r_k + 1'b1;
                    n_state     = res_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_FIN;
                    n_first     = '0;
                    n_final     = '0;
                    n_trunc     = 1'b0;
                    n_last      = 1'b1;
                    n_cnt_out   = COUNT_W'(r_count);
                    n_high_out  = RANGE_W'(r_highest);
                    n_finished  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_expected  <= '0;
            r_highest   <= '0;
            r_count     <= '0;
            r_finished  <= 1'b0;
            r_issuing   <= 1'b0;
            r_pv        <= 1'b0;
            r_in_run    <= 1'b0;
            r_runs      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_expected  <= n_expected;
            r_highest   <= n_highest;
            r_count     <= n_count;
            r_finished  <= n_finished;
            r_issuing   <= n_issuing;
            r_pv        <= n_pv;
            r_in_run    <= n_in_run;
            r_runs      <= n_runs;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_start    <= n_start;
        r_seq      <= n_seq;
        r_kind     <= n_kind;
        r_first    <= n_first;
        r_final    <= n_final;
        r_trunc    <= n_trunc;
        r_last     <= n_last;
        r_cnt_out  <= n_cnt_out;
        r_high_out <= n_high_out;
    end

    // Run table: write during the walk, registered read while emitting
    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res_mem[res_waddr] <= res_wdata;
        end
        if (r_state == ST_EMIT_RD) begin
            r_res_rd <= r_res_mem[r_k[RW-1:0]];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.range_first    = r_first;
    assign o_out.range_final    = r_final;
    assign o_out.truncated      = r_trunc;
    assign o_out.last           = r_last;
    assign o_out.count_received = r_cnt_out;
    assign o_out.highest_seen   = r_high_out;

endmodule
